FILE: rtl/core/proximity_union_find_connectivity_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the proximity connectivity core
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_UNION_FIND_CONNECTIVITY_CORE_MACROS_SVH
`define PROXIMITY_UNION_FIND_CONNECTIVITY_CORE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PUFC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pufc assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PUFC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pufc assertion failed");

`endif

FILE: rtl/core/pufc_pkg.sv
// ----------------------------------------------------------------------------
// pufc_pkg
// Types, codes and constants shared by the proximity connectivity core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pufc_pkg;

  localparam int NODES_DEF = 1024;
  localparam int ADDR_W    = 16;
  localparam int RANK_W    = 4;
  localparam int COORD_W   = 16;
  localparam int CNT_CFG_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int SQ_W      = 34;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH      = 2'd1;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_ACTIVATE = 2'd1,
    OP_QUERY    = 2'd2
  } opcode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACT_INIT,
    ST_ACT_COORD,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_DY,
    ST_SCAN_CMP,
    ST_FIND_RD,
    ST_FIND_WALK,
    ST_COMP_RD,
    ST_COMP_WALK,
    ST_JOIN,
    ST_QUERY_OUT
  } state_e;

  // Access to the parent and rank tables.
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              parent_we;
    logic [ADDR_W-1:0] parent_waddr;
    logic [ADDR_W-1:0] parent_wdata;
    logic              rank_we;
    logic [ADDR_W-1:0] rank_waddr;
    logic [RANK_W-1:0] rank_wdata;
  } uf_port_t;

  // Access to the coordinate and active tables.
  typedef struct packed {
    logic [ADDR_W-1:0]  rd_addr;
    logic               coord_we;
    logic               act_we;
    logic [ADDR_W-1:0]  waddr;
    logic [COORD_W-1:0] x_wdata;
    logic [COORD_W-1:0] y_wdata;
    logic               act_wdata;
  } nd_port_t;

endpackage

FILE: rtl/core/pufc_sqdiff.sv
// ----------------------------------------------------------------------------
// pufc_sqdiff
// Shared unit: registered square of the absolute difference of two values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pufc_sqdiff (
  input  logic                          clk_i,
  input  logic signed [16:0]            p_i,
  input  logic signed [16:0]            q_i,
  output logic [pufc_pkg::SQ_W-1:0]     sq_o
);

  logic signed [17:0] diff;
  logic [16:0]        mag;
  logic [pufc_pkg::SQ_W-1:0] sq_q;

  assign diff = 18'(p_i) - 18'(q_i);
  assign mag  = diff[17] ? 17'(-diff) : diff[16:0];

  always_ff @(posedge clk_i) begin
    sq_q <= pufc_pkg::SQ_W'(mag) * pufc_pkg::SQ_W'(mag);
  end

  assign sq_o = sq_q;

endmodule

FILE: rtl/core/pufc_store.sv
// ----------------------------------------------------------------------------
// pufc_store
// Node tables: parent links, ranks, coordinates and active marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pufc_store #(
  parameter int NODES = pufc_pkg::NODES_DEF,
  parameter int IDX_W = $clog2(NODES)
) (
  input  logic                           clk_i,
  input  pufc_pkg::uf_port_t             uf_i,
  input  pufc_pkg::nd_port_t             nd_i,
  output logic [IDX_W-1:0]               parent_rdata_o,
  output logic [pufc_pkg::RANK_W-1:0]    rank_rdata_o,
  output logic [pufc_pkg::COORD_W-1:0]   x_rdata_o,
  output logic [pufc_pkg::COORD_W-1:0]   y_rdata_o,
  output logic                           act_rdata_o
);

  logic [IDX_W-1:0]             parent_mem [NODES];
  logic [pufc_pkg::RANK_W-1:0]  rank_mem   [NODES];
  logic [pufc_pkg::COORD_W-1:0] x_mem      [NODES];
  logic [pufc_pkg::COORD_W-1:0] y_mem      [NODES];
  logic                         act_mem    [NODES];

  always_ff @(posedge clk_i) begin
    if (uf_i.parent_we) begin
      parent_mem[uf_i.parent_waddr[IDX_W-1:0]] <= uf_i.parent_wdata[IDX_W-1:0];
    end
    parent_rdata_o <= parent_mem[uf_i.rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (uf_i.rank_we) begin
      rank_mem[uf_i.rank_waddr[IDX_W-1:0]] <= uf_i.rank_wdata;
    end
    rank_rdata_o <= rank_mem[uf_i.rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (nd_i.coord_we) begin
      x_mem[nd_i.waddr[IDX_W-1:0]] <= nd_i.x_wdata;
      y_mem[nd_i.waddr[IDX_W-1:0]] <= nd_i.y_wdata;
    end
    x_rdata_o <= x_mem[nd_i.rd_addr[IDX_W-1:0]];
    y_rdata_o <= y_mem[nd_i.rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (nd_i.act_we) begin
      act_mem[nd_i.waddr[IDX_W-1:0]] <= nd_i.act_wdata;
    end
    act_rdata_o <= act_mem[nd_i.rd_addr[IDX_W-1:0]];
  end

endmodule

FILE: rtl/core/proximity_union_find_connectivity_core.sv
// ----------------------------------------------------------------------------
// proximity_union_find_connectivity_core
// Disjoint-set table over nodes, joined by Euclidean proximity on activation.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. The result of a
// query appears on connected_o for exactly one cycle while done_o is high;
// the receiver cannot stall, so it must take the result in that cycle. After
// reset the block sweeps its tables (parent links to their own index, ranks
// and active marks to zero) and holds busy_o high meanwhile; configuration
// writes are taken at any time. A load is written from the idle state and
// leaves busy_o low. A query with both nodes in range runs two finds, each
// walking to the root and pointing the path at it, then the output state.
// An activation reads and checks each node below the node count, squares
// and compares dx and dy for active ones, and adds two finds and a join for
// each in reach. The time is set by the single table read port, which walks
// parent links one step per cycle, and by the one shared squaring unit,
// used once for dx and once for dy per candidate node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module proximity_union_find_connectivity_core #(
  parameter int NODES = pufc_pkg::NODES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        opcode_i,
  input  logic [9:0]                        node_a_i,
  input  logic [9:0]                        node_b_i,
  input  logic signed [15:0]                pos_x_i,
  input  logic signed [15:0]                pos_y_i,
  output logic                              done_o,
  output logic                              connected_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pufc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pufc_pkg::CFG_DAT_W-1:0]    cfg_data_i
);

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int AW    = pufc_pkg::ADDR_W;
  localparam int RW    = pufc_pkg::RANK_W;

  pufc_pkg::state_e state_q, state_d;

  // Control registers.
  logic [CNT_W-1:0] i_q, i_d;
  logic             pass_q, pass_d;
  logic             query_q, query_d;
  logic             oor_q, oor_d;
  logic             done_q, done_d;
  logic             conn_q, conn_d;
  logic [pufc_pkg::CNT_CFG_W-1:0] node_count_q;
  logic [15:0]                    reach_q;

  // Datapath registers.
  logic [IDX_W-1:0] a_q, a_d, b_q, b_d, fs_q, fs_d, r_q, r_d, n_q, n_d;
  logic [IDX_W-1:0] root_q, root_d, ra_q, ra_d, rb_q, rb_d;
  logic [RW-1:0]    rk_q, rk_d, rka_q, rka_d, rkb_q, rkb_d;
  logic [15:0]      xa_q, xa_d, ya_q, ya_d, yi_q, yi_d;
  logic [pufc_pkg::SQ_W-1:0] reach2_q, reach2_d, dx2_q, dx2_d;

  pufc_pkg::uf_port_t uf;
  pufc_pkg::nd_port_t nd;
  logic [IDX_W-1:0]   parent_rd;
  logic [RW-1:0]      rank_rd;
  logic [15:0]        x_rd, y_rd;
  logic               act_rd;

  logic signed [16:0]        mul_p, mul_q;
  logic [pufc_pkg::SQ_W-1:0] mul_sq;

  logic             accept;
  logic             a_ok, b_ok;
  logic [CNT_W-1:0] limit;
  logic [IDX_W-1:0] i_idx;
  logic             in_reach;

  assign busy_o      = (state_q != pufc_pkg::ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign connected_o = conn_q;

  assign a_ok  = (32'(node_a_i) < NODES);
  assign b_ok  = (32'(node_b_i) < NODES);
  assign limit = (32'(node_count_q) >= NODES) ? CNT_W'(NODES) : CNT_W'(node_count_q);
  assign i_idx = i_q[IDX_W-1:0];
  assign in_reach = ((35'(dx2_q) + 35'(mul_sq)) <= 35'(reach2_q));

  pufc_store #(
    .NODES(NODES),
    .IDX_W(IDX_W)
  ) u_store (
    .clk_i          (clk_i),
    .uf_i           (uf),
    .nd_i           (nd),
    .parent_rdata_o (parent_rd),
    .rank_rdata_o   (rank_rd),
    .x_rdata_o      (x_rd),
    .y_rdata_o      (y_rd),
    .act_rdata_o    (act_rd)
  );

  pufc_sqdiff u_sqdiff (
    .clk_i (clk_i),
    .p_i   (mul_p),
    .q_i   (mul_q),
    .sq_o  (mul_sq)
  );

  // Config regs; writes must be issued only while idle (user rule, unchecked).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd1024;
      reach_q      <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pufc_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[pufc_pkg::CNT_CFG_W-1:0];
        pufc_pkg::CFG_REACH:      reach_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pufc_pkg::ST_CLEAR: begin
        if (i_idx == IDX_W'(NODES - 1)) begin
          state_d = pufc_pkg::ST_IDLE;
        end
      end
      pufc_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode_i == pufc_pkg::OP_ACTIVATE && a_ok) begin
            state_d = pufc_pkg::ST_ACT_INIT;
          end else if (opcode_i == pufc_pkg::OP_QUERY) begin
            state_d = (a_ok && b_ok) ? pufc_pkg::ST_FIND_RD : pufc_pkg::ST_QUERY_OUT;
          end
        end
      end
      pufc_pkg::ST_ACT_INIT:  state_d = pufc_pkg::ST_ACT_COORD;
      pufc_pkg::ST_ACT_COORD: state_d = pufc_pkg::ST_SCAN_RD;
      pufc_pkg::ST_SCAN_RD: begin
        state_d = (i_q >= limit) ? pufc_pkg::ST_IDLE : pufc_pkg::ST_SCAN_CHK;
      end
      pufc_pkg::ST_SCAN_CHK: begin
        state_d = (i_idx == a_q || !act_rd) ? pufc_pkg::ST_SCAN_RD : pufc_pkg::ST_SCAN_DY;
      end
      pufc_pkg::ST_SCAN_DY:  state_d = pufc_pkg::ST_SCAN_CMP;
      pufc_pkg::ST_SCAN_CMP: begin
        state_d = in_reach ? pufc_pkg::ST_FIND_RD : pufc_pkg::ST_SCAN_RD;
      end
      pufc_pkg::ST_FIND_RD: state_d = pufc_pkg::ST_FIND_WALK;
      pufc_pkg::ST_FIND_WALK: begin
        if (parent_rd == r_q) begin
          state_d = pufc_pkg::ST_COMP_RD;
        end
      end
      pufc_pkg::ST_COMP_RD: state_d = pufc_pkg::ST_COMP_WALK;
      pufc_pkg::ST_COMP_WALK: begin
        if (parent_rd == root_q) begin
          if (!pass_q) begin
            state_d = pufc_pkg::ST_FIND_RD;
          end else begin
            state_d = query_q ? pufc_pkg::ST_QUERY_OUT : pufc_pkg::ST_JOIN;
          end
        end
      end
      pufc_pkg::ST_JOIN:      state_d = pufc_pkg::ST_SCAN_RD;
      pufc_pkg::ST_QUERY_OUT: state_d = pufc_pkg::ST_IDLE;
      default:                state_d = pufc_pkg::ST_IDLE;
    endcase
  end

  // Datapath, table access and result.
  always_comb begin
    i_d      = i_q;
    pass_d   = pass_q;
    query_d  = query_q;
    oor_d    = oor_q;
    done_d   = 1'b0;
    conn_d   = conn_q;
    a_d      = a_q;
    b_d      = b_q;
    fs_d     = fs_q;
    r_d      = r_q;
    n_d      = n_q;
    root_d   = root_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    rk_d     = rk_q;
    rka_d    = rka_q;
    rkb_d    = rkb_q;
    xa_d     = xa_q;
    ya_d     = ya_q;
    yi_d     = yi_q;
    reach2_d = reach2_q;
    dx2_d    = dx2_q;
    mul_p    = 17'sd0;
    mul_q    = 17'sd0;
    uf       = '0;
    nd       = '0;

    case (state_q)
      pufc_pkg::ST_CLEAR: begin
        // Reset sweep: every node becomes its own root, rank zero, inactive.
        uf.parent_we    = 1'b1;
        uf.parent_waddr = AW'(i_idx);
        uf.parent_wdata = AW'(i_idx);
        uf.rank_we      = 1'b1;
        uf.rank_waddr   = AW'(i_idx);
        nd.act_we       = 1'b1;
        nd.waddr        = AW'(i_idx);
        i_d             = i_q + CNT_W'(1);
      end
      pufc_pkg::ST_IDLE: begin
        a_d    = IDX_W'(node_a_i);
        b_d    = IDX_W'(node_b_i);
        fs_d   = IDX_W'(node_a_i);
        pass_d = 1'b0;
        if (accept) begin
          query_d = (opcode_i == pufc_pkg::OP_QUERY);
          oor_d   = !(a_ok && b_ok);
          if (opcode_i == pufc_pkg::OP_LOAD && a_ok) begin
            nd.coord_we = 1'b1;
            nd.waddr    = AW'(IDX_W'(node_a_i));
            nd.x_wdata  = pos_x_i;
            nd.y_wdata  = pos_y_i;
          end
        end
      end
      pufc_pkg::ST_ACT_INIT: begin
        nd.act_we     = 1'b1;
        nd.act_wdata  = 1'b1;
        nd.waddr      = AW'(a_q);
        nd.rd_addr    = AW'(a_q);
        // The shared unit squares the reach while the coordinates are read.
        mul_p         = $signed({1'b0, reach_q});
      end
      pufc_pkg::ST_ACT_COORD: begin
        xa_d     = x_rd;
        ya_d     = y_rd;
        reach2_d = mul_sq;
        i_d      = '0;
      end
      pufc_pkg::ST_SCAN_RD: begin
        nd.rd_addr = AW'(i_idx);
      end
      pufc_pkg::ST_SCAN_CHK: begin
        mul_p = 17'(signed'(x_rd));
        mul_q = 17'(signed'(xa_q));
        yi_d  = y_rd;
        if (i_idx == a_q || !act_rd) begin
          i_d = i_q + CNT_W'(1);
        end
      end
      pufc_pkg::ST_SCAN_DY: begin
        mul_p = 17'(signed'(yi_q));
        mul_q = 17'(signed'(ya_q));
        dx2_d = mul_sq;
      end
      pufc_pkg::ST_SCAN_CMP: begin
        pass_d = 1'b0;
        fs_d   = a_q;
        if (!in_reach) begin
          i_d = i_q + CNT_W'(1);
        end
      end
      pufc_pkg::ST_FIND_RD: begin
        uf.rd_addr = AW'(fs_q);
        r_d        = fs_q;
      end
      pufc_pkg::ST_FIND_WALK: begin
        // One parent link per cycle until a node points at itself.
        if (parent_rd == r_q) begin
          root_d = r_q;
          rk_d   = rank_rd;
        end else begin
          uf.rd_addr = AW'(parent_rd);
          r_d        = parent_rd;
        end
      end
      pufc_pkg::ST_COMP_RD: begin
        uf.rd_addr = AW'(fs_q);
        n_d        = fs_q;
      end
      pufc_pkg::ST_COMP_WALK: begin
        // Second walk over the same path points every node at the root.
        if (parent_rd == root_q) begin
          if (!pass_q) begin
            ra_d   = root_q;
            rka_d  = rk_q;
            pass_d = 1'b1;
            fs_d   = query_q ? b_q : i_idx;
          end else begin
            rb_d  = root_q;
            rkb_d = rk_q;
          end
        end else begin
          uf.parent_we    = 1'b1;
          uf.parent_waddr = AW'(n_q);
          uf.parent_wdata = AW'(root_q);
          uf.rd_addr      = AW'(parent_rd);
          n_d             = parent_rd;
        end
      end
      pufc_pkg::ST_JOIN: begin
        if (ra_q != rb_q) begin
          uf.parent_we = 1'b1;
          if (rka_q < rkb_q) begin
            uf.parent_waddr = AW'(ra_q);
            uf.parent_wdata = AW'(rb_q);
          end else begin
            uf.parent_waddr = AW'(rb_q);
            uf.parent_wdata = AW'(ra_q);
            if (rka_q == rkb_q && rka_q < pufc_pkg::RANK_MAX) begin
              uf.rank_we    = 1'b1;
              uf.rank_waddr = AW'(ra_q);
              uf.rank_wdata = rka_q + RW'(1);
            end
          end
        end
        i_d = i_q + CNT_W'(1);
      end
      pufc_pkg::ST_QUERY_OUT: begin
        done_d = 1'b1;
        conn_d = !oor_q && (ra_q == rb_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pufc_pkg::ST_CLEAR;
      i_q     <= '0;
      pass_q  <= 1'b0;
      query_q <= 1'b0;
      oor_q   <= 1'b0;
      done_q  <= 1'b0;
      conn_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      pass_q  <= pass_d;
      query_q <= query_d;
      oor_q   <= oor_d;
      done_q  <= done_d;
      conn_q  <= conn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    fs_q     <= fs_d;
    r_q      <= r_d;
    n_q      <= n_d;
    root_q   <= root_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    rk_q     <= rk_d;
    rka_q    <= rka_d;
    rkb_q    <= rkb_d;
    xa_q     <= xa_d;
    ya_q     <= ya_d;
    yi_q     <= yi_d;
    reach2_q <= reach2_d;
    dx2_q    <= dx2_d;
  end

endmodule

FILE: rtl/core/pufc_checker.sv
// ----------------------------------------------------------------------------
// pufc_checker
// Port-level checks of the proximity connectivity core over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "proximity_union_find_connectivity_core_macros.svh"

module pufc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] opcode_i,
  input logic       done_o
);

  // A query always runs through the sequencer before its result.
  `PUFC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, start_i && !busy_o && opcode_i == pufc_pkg::OP_QUERY, busy_o)

  // Results are spaced apart: no two strobes in a row.
  `PUFC_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)

  // A result only follows a cycle in which the block was busy.
  `PUFC_ASSERT_NOW(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy_o))

endmodule

bind proximity_union_find_connectivity_core pufc_checker u_pufc_checker (.*);
